// ----- sv/sud_pkg.sv -----
`timescale 1ns / 1ps
// Package for the SGR / UTF-8 row decoder: shared types, codes and the
// SGR parameter functions. Depends on nothing.
package sud_pkg;

  localparam logic [8:0] MAX_COLS = 9'd256;
  localparam logic [8:0] ROW_WIDTH_RESET = 9'd80;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_SGR  = 2'd2;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_FINAL_M = 8'h6D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_ESC         = 21'h00001B;

  localparam logic [15:0] SGR_RESET     = 16'd0;
  localparam logic [15:0] SGR_BOLD      = 16'd1;
  localparam logic [15:0] SGR_DIM       = 16'd2;
  localparam logic [15:0] SGR_ITALIC    = 16'd3;
  localparam logic [15:0] SGR_UNDERLINE = 16'd4;
  localparam logic [15:0] SGR_BLINK     = 16'd5;
  localparam logic [15:0] SGR_INVERSE   = 16'd7;
  localparam logic [15:0] SGR_INVISIBLE = 16'd8;
  localparam logic [15:0] SGR_STRIKE    = 16'd9;
  localparam logic [15:0] SGR_FG_EXT    = 16'd38;
  localparam logic [15:0] SGR_FG_DEF    = 16'd39;
  localparam logic [15:0] SGR_BG_EXT    = 16'd48;
  localparam logic [15:0] SGR_BG_DEF    = 16'd49;
  localparam logic [15:0] SGR_WIDE      = 16'd100;
  localparam logic [15:0] SGR_SPACER    = 16'd101;
  localparam logic [15:0] SGR_TRUECOLOR = 16'd2;

  localparam logic [2:0] CPH_IDLE  = 3'd0;
  localparam logic [2:0] CPH_MODE  = 3'd1;
  localparam logic [2:0] CPH_RED   = 3'd2;
  localparam logic [2:0] CPH_GREEN = 3'd3;
  localparam logic [2:0] CPH_BLUE  = 3'd4;

  // Attribute and color-sequence state touched by SGR parameters.
  typedef struct packed {
    logic [9:0]  flags;
    logic [24:0] fg;
    logic [24:0] bg;
    logic [2:0]  cphase;
    logic        is_bg;
    logic [15:0] held0;
    logic [15:0] held1;
  } sgr_t;

  // One output cell.
  typedef struct packed {
    logic [20:0] code_point;
    logic [7:0]  column;
    logic [9:0]  attr_flags;
    logic        fg_is_rgb;
    logic [23:0] fg_rgb;
    logic        bg_is_rgb;
    logic [23:0] bg_rgb;
    logic        row_done;
  } cell_t;

  function automatic sgr_t apply_param(sgr_t s, logic [15:0] v);
    sgr_t r;
    logic normal;
    logic [24:0] c;
    r = s;
    normal = 1'b0;
    c = {1'b1, s.held0[7:0], s.held1[7:0], v[7:0]};
    case (s.cphase)
      CPH_IDLE: normal = 1'b1;
      CPH_MODE: begin
        if (v == SGR_TRUECOLOR) begin
          r.cphase = CPH_RED;
        end else begin
          r.cphase = CPH_IDLE;
          normal = 1'b1;
        end
      end
      CPH_RED: begin
        r.held0 = v;
        r.cphase = CPH_GREEN;
      end
      CPH_GREEN: begin
        r.held1 = v;
        r.cphase = CPH_BLUE;
      end
      default: begin
        if (s.is_bg) r.bg = c;
        else r.fg = c;
        r.cphase = CPH_IDLE;
      end
    endcase
    if (normal) begin
      case (v)
        SGR_RESET: begin
          r.flags = '0;
          r.fg = '0;
          r.bg = '0;
        end
        SGR_BOLD:      r.flags[0] = 1'b1;
        SGR_DIM:       r.flags[1] = 1'b1;
        SGR_ITALIC:    r.flags[2] = 1'b1;
        SGR_UNDERLINE: r.flags[3] = 1'b1;
        SGR_BLINK:     r.flags[4] = 1'b1;
        SGR_INVERSE:   r.flags[5] = 1'b1;
        SGR_INVISIBLE: r.flags[6] = 1'b1;
        SGR_STRIKE:    r.flags[7] = 1'b1;
        SGR_FG_DEF:    r.fg = '0;
        SGR_BG_DEF:    r.bg = '0;
        SGR_FG_EXT: begin
          r.cphase = CPH_MODE;
          r.is_bg = 1'b0;
        end
        SGR_BG_EXT: begin
          r.cphase = CPH_MODE;
          r.is_bg = 1'b1;
        end
        SGR_WIDE:      r.flags[8] = 1'b1;
        SGR_SPACER:    r.flags[9] = 1'b1;
        default: ;
      endcase
    end
    return r;
  endfunction

  // End of a run: an unfinished color sequence is dropped and the
  // parameters it swallowed are replayed. Three rounds always settle it.
  function automatic sgr_t flush_color(sgr_t s);
    sgr_t r;
    logic [2:0] ph;
    logic [15:0] h0;
    logic [15:0] h1;
    r = s;
    for (int i = 0; i < 3; i++) begin
      ph = r.cphase;
      h0 = r.held0;
      h1 = r.held1;
      r.cphase = CPH_IDLE;
      if (ph >= CPH_RED) r = apply_param(r, SGR_TRUECOLOR);
      if (ph >= CPH_GREEN) r = apply_param(r, h0);
      if (ph >= CPH_BLUE) r = apply_param(r, h1);
    end
    return r;
  endfunction

endpackage

// ----- sv/sgr_utf8_row_decoder_unit.sv -----
`timescale 1ns / 1ps
// Top level of the SGR / UTF-8 row decoder: parser, decoder and output queue.
// Depends on sud_pkg.
//
// Usage: bytes of one archived terminal row enter on the input channel
// (valid_i / stall_o), with last_byte_i set on the final byte. Each decoded
// character leaves as one word on the output channel (valid_o / stall_i),
// carrying code point, column and the attributes in force. A byte may give
// zero, one or two words.
// Each word is registered into the output queue when its byte is taken.
// Throughput: one byte per cycle; the only limit is the output port, which
// moves one word a cycle when not stalled, so bytes that give two words slow
// the stream. The parser state advances in one step per byte between the
// input handshake and a four-word output queue; stall_o rises once fewer than
// two queue slots are free, so a byte is only taken when all its words fit.
// Reset: the queue empties, the parser returns to plain text with default
// attributes, and the row width returns to 80 columns. The user must write the
// row width through cfg_we_i / cfg_wdata_i only while the block is idle; the
// block itself does not enforce it. When the receiver stalls, the head word
// holds steady and the queue keeps taking bytes until it is nearly full.
module sgr_utf8_row_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [20:0] code_point_o,
  output logic [7:0]  column_o,
  output logic [9:0]  attr_flags_o,
  output logic        fg_is_rgb_o,
  output logic [23:0] fg_rgb_o,
  output logic        bg_is_rgb_o,
  output logic [23:0] bg_rgb_o,
  output logic        row_done_o
);
  import sud_pkg::*;

  logic [8:0]  row_width_q;
  logic [1:0]  phase_q, phase_d;
  logic [20:0] acc_q, acc_d;
  logic [1:0]  pend_q, pend_d;
  logic [15:0] pv_q, pv_d;
  logic        pp_q, pp_d;
  sgr_t        sgr_q, sgr_d;
  logic [8:0]  col_q, col_d;

  logic        accept;
  logic [7:0]  b;
  logic [2:0]  cand_v;
  logic [20:0] cand_cp [3];
  logic        cont;
  logic [20:0] acc_new;
  logic [19:0] digit_val;
  logic [8:0]  w;
  logic [20:0] cp0, cp1;
  logic        e0, e1;
  cell_t       cell0, cell1;

  cell_t       fifo_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;
  logic        pop;
  logic [1:0]  push_n;

  assign accept = valid_i && !stall_o;
  assign b = data_byte_i;
  assign w = (row_width_q > MAX_COLS) ? MAX_COLS : row_width_q;
  assign digit_val = {1'b0, pv_q, 3'b000} + {3'b000, pv_q, 1'b0} + {16'd0, b[3:0]};
  assign acc_new = {acc_q[14:0], b[5:0]};

  // Byte handling. Three candidate cells can be raised, in slot order; the first
  // two raised are emitted while they fit in the row.
  always_comb begin
    phase_d = phase_q;
    acc_d = acc_q;
    pend_d = pend_q;
    pv_d = pv_q;
    pp_d = pp_q;
    sgr_d = sgr_q;
    cand_v = 3'b000;
    cand_cp[0] = CP_ESC;
    cand_cp[1] = CP_REPLACEMENT;
    cand_cp[2] = CP_REPLACEMENT;
    cont = 1'b0;

    unique case (phase_q)
      PH_SGR: begin
        if (b >= 8'h30 && b <= 8'h39) begin
          pv_d = (digit_val > 20'hFFFF) ? 16'hFFFF : digit_val[15:0];
          pp_d = 1'b1;
        end else if (b == CH_SEMI) begin
          sgr_d = apply_param(sgr_q, pv_q);
          pv_d = '0;
          pp_d = 1'b0;
        end else if (b == CH_FINAL_M) begin
          sgr_d = flush_color(pp_q ? apply_param(sgr_q, pv_q) : sgr_q);
          pv_d = '0;
          pp_d = 1'b0;
          phase_d = PH_TEXT;
        end
      end
      default: begin
        if (phase_q == PH_ESC) begin
          if (b == CH_BRACKET) begin
            phase_d = PH_SGR;
            pv_d = '0;
            pp_d = 1'b0;
            sgr_d.cphase = CPH_IDLE;
          end else begin
            phase_d = PH_TEXT;
            cand_v[0] = 1'b1;
            cand_cp[0] = CP_ESC;
          end
        end else if (pend_q != 2'd0) begin
          cont = (b[7:6] == 2'b10);
          if (pend_q == 2'd2 && acc_q == 21'h0 && b < 8'hA0) cont = 1'b0;
          if (pend_q == 2'd2 && acc_q == 21'hD && b > 8'h9F) cont = 1'b0;
          if (pend_q == 2'd3 && acc_q == 21'h0 && b < 8'h90) cont = 1'b0;
          if (pend_q == 2'd3 && acc_q == 21'h4 && b > 8'h8F) cont = 1'b0;
          if (cont) begin
            pend_d = pend_q - 2'd1;
            acc_d = acc_new;
            if (pend_q == 2'd1) begin
              cand_v[0] = 1'b1;
              cand_cp[0] = acc_new;
              acc_d = '0;
            end
          end else begin
            pend_d = 2'd0;
            acc_d = '0;
            cand_v[0] = 1'b1;
            cand_cp[0] = CP_REPLACEMENT;
          end
        end

        // A fresh byte in text, unless it continued a sequence or opened a run.
        if (!cont && !(phase_q == PH_ESC && b == CH_BRACKET)) begin
          if (b == CH_ESC) begin
            phase_d = PH_ESC;
          end else if (b < 8'h80) begin
            cand_v[1] = 1'b1;
            cand_cp[1] = {13'd0, b};
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            acc_d = {16'd0, b[4:0]};
            pend_d = 2'd1;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            acc_d = {17'd0, b[3:0]};
            pend_d = 2'd2;
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            acc_d = {18'd0, b[2:0]};
            pend_d = 2'd3;
          end else begin
            cand_v[1] = 1'b1;
            cand_cp[1] = CP_REPLACEMENT;
          end
        end
      end
    endcase

    // The final byte closes an open escape or cut-short character; state resets.
    if (last_byte_i) begin
      if (phase_d == PH_ESC) begin
        cand_v[2] = 1'b1;
        cand_cp[2] = CP_ESC;
      end else if (phase_d == PH_TEXT && pend_d != 2'd0) begin
        cand_v[2] = 1'b1;
        cand_cp[2] = CP_REPLACEMENT;
      end
      phase_d = PH_TEXT;
      acc_d = '0;
      pend_d = '0;
      pv_d = '0;
      pp_d = 1'b0;
      sgr_d.flags = '0;
      sgr_d.fg = '0;
      sgr_d.bg = '0;
      sgr_d.cphase = CPH_IDLE;
      sgr_d.is_bg = 1'b0;
    end
  end

  // Pick the first two raised candidates and check them against the row.
  always_comb begin
    cp0 = cand_v[0] ? cand_cp[0] : (cand_v[1] ? cand_cp[1] : cand_cp[2]);
    cp1 = (cand_v[0] && cand_v[1]) ? cand_cp[1] : cand_cp[2];
    e0 = (cand_v != 3'b000) && (col_q < w);
    e1 = ($countones(cand_v) >= 2) && ({1'b0, col_q} + 10'd1 < {1'b0, w});

    cell0.code_point = (cp0 == {13'd0, CH_SPACE}) ? 21'd0 : cp0;
    cell0.column = col_q[7:0];
    cell0.attr_flags = sgr_q.flags;
    cell0.fg_is_rgb = sgr_q.fg[24];
    cell0.fg_rgb = sgr_q.fg[24] ? sgr_q.fg[23:0] : 24'd0;
    cell0.bg_is_rgb = sgr_q.bg[24];
    cell0.bg_rgb = sgr_q.bg[24] ? sgr_q.bg[23:0] : 24'd0;
    cell0.row_done = ({1'b0, col_q} + 10'd1 == {1'b0, w}) || (last_byte_i && !e1);

    cell1 = cell0;
    cell1.code_point = (cp1 == {13'd0, CH_SPACE}) ? 21'd0 : cp1;
    cell1.column = col_q[7:0] + 8'd1;
    cell1.row_done = ({1'b0, col_q} + 10'd2 == {1'b0, w}) || last_byte_i;

    if (last_byte_i) col_d = '0;
    else col_d = col_q + {8'd0, e0} + {8'd0, e1};
  end

  assign push_n = accept ? ({1'b0, e0} + {1'b0, e1}) : 2'd0;
  assign pop = valid_o && !stall_i;
  assign stall_o = cnt_q > 3'd2;
  assign valid_o = cnt_q != 3'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
      phase_q <= PH_TEXT;
      acc_q <= '0;
      pend_q <= '0;
      pv_q <= '0;
      pp_q <= 1'b0;
      sgr_q <= '0;
      col_q <= '0;
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) row_width_q <= cfg_wdata_i;
      if (accept) begin
        phase_q <= phase_d;
        acc_q <= acc_d;
        pend_q <= pend_d;
        pv_q <= pv_d;
        pp_q <= pp_d;
        sgr_q <= sgr_d;
        col_q <= col_d;
      end
      wr_q <= wr_q + push_n;
      rd_q <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
    end
  end

  // The queue storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (e0) fifo_q[wr_q] <= cell0;
      if (e1) fifo_q[wr_q + 2'd1] <= cell1;
    end
  end

  assign code_point_o = fifo_q[rd_q].code_point;
  assign column_o = fifo_q[rd_q].column;
  assign attr_flags_o = fifo_q[rd_q].attr_flags;
  assign fg_is_rgb_o = fifo_q[rd_q].fg_is_rgb;
  assign fg_rgb_o = fifo_q[rd_q].fg_rgb;
  assign bg_is_rgb_o = fifo_q[rd_q].bg_is_rgb;
  assign bg_rgb_o = fifo_q[rd_q].bg_rgb;
  assign row_done_o = fifo_q[rd_q].row_done;

endmodule
